FILE: rtl/core/fpns_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpns_pkg
// Shared widths and reset values for the fixed-point Newton square root.
// ----------------------------------------------------------------------------
package fpns_pkg;

    localparam int DATA_W            = 32;
    localparam int PROD_W            = 64;
    localparam int ITER_W            = 8;
    localparam int FRAC_BITS_DEFAULT = 16;

    localparam logic [ITER_W-1:0] ITER_COUNT_RESET = 8'd8;

    // starting guess is 10.0 in the chosen fixed-point format
    localparam logic [DATA_W-1:0] GUESS_INT = 32'd10;

endpackage
// ----------------------------------------------------------------------------

FILE: rtl/core/fixed_point_newton_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_newton_sqrt
// Square root of a signed fixed-point value by repeated Newton steps.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_radicand take one radicand per transfer. s_ready is
//   high only while the sequencer is idle; one radicand is worked at a time.
//   m_valid/m_ready/m_root/m_divide_by_zero give one result per radicand.
//   cfg_valid/cfg_ready/cfg_data write iteration_count (low 8 bits); write it
//   only while no radicand is in flight. cfg_ready is always high.
// Steps: each Newton step passes through the 32x32 multiplier, then rounding,
//   numerator and sign handling, then the one-bit-per-cycle restoring
//   divider, then the update and loop test; N steps run, N being
//   iteration_count. A step that meets a zero divisor skips the divider.
//   A new radicand is taken only once the previous one has left the sequencer.
// Reset: aresetn is synchronous, active low; clears the sequencer and the
//   output valid and sets iteration_count to 8.
// Stall: a finished result sits in the output register while m_ready is low;
//   the sequencer goes back to idle and takes the next radicand meanwhile,
//   and waits at its end only if the output register is still full.
// ----------------------------------------------------------------------------
module fixed_point_newton_sqrt #(
    parameter int FRAC_BITS = fpns_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [fpns_pkg::DATA_W-1:0] s_radicand,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [fpns_pkg::DATA_W-1:0] m_root,
    output logic                          m_divide_by_zero,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fpns_pkg::ITER_W-1:0]   cfg_data
);

    localparam int DW = fpns_pkg::DATA_W;
    localparam int PW = fpns_pkg::PROD_W;
    localparam int IW = fpns_pkg::ITER_W;
    localparam int CW = $clog2(PW);

    localparam logic [DW-1:0] INIT_GUESS = DW'(fpns_pkg::GUESS_INT << FRAC_BITS);
    localparam logic [PW-1:0] ROUND_HALF = PW'(64'd1 << (FRAC_BITS - 1));
    localparam logic [CW-1:0] DIV_LAST   = CW'(PW - 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CHK  = 4'd1;
    localparam logic [3:0] ST_MUL  = 4'd2;
    localparam logic [3:0] ST_RND  = 4'd3;
    localparam logic [3:0] ST_NUM  = 4'd4;
    localparam logic [3:0] ST_ABS  = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_FIN  = 4'd7;
    localparam logic [3:0] ST_UPD  = 4'd8;

    logic [3:0]    state_reg,  state_next;
    logic [IW-1:0] iter_count_reg, iter_count_next;
    logic [IW-1:0] step_reg,   step_next;
    logic [CW-1:0] cnt_reg,    cnt_next;
    logic [DW-1:0] rad_reg,    rad_next;
    logic [DW-1:0] guess_reg,  guess_next;
    logic          dz_reg,     dz_next;
    logic [PW-1:0] prod_reg,   prod_next;
    logic [DW-1:0] diff_reg,   diff_next;
    logic [PW-1:0] num_reg,    num_next;
    logic [PW-1:0] dq_reg,     dq_next;
    logic [DW-1:0] rem_reg,    rem_next;
    logic [DW-1:0] den_reg,    den_next;
    logic          neg_reg,    neg_next;
    logic          out_valid_reg, out_valid_next;
    logic [DW-1:0] out_root_reg,  out_root_next;
    logic          out_dz_reg,    out_dz_next;

    logic [PW-1:0] rnd_sum;
    logic [DW-1:0] twice;
    logic [DW-1:0] twice_abs;
    logic [PW-1:0] num_calc;
    logic [PW-1:0] num_abs;
    logic [DW:0]   div_shift;
    logic [DW+1:0] div_trial;
    logic          div_ge;
    logic [DW-1:0] quot;
    logic          out_free;

    assign twice     = {guess_reg[DW-2:0], 1'b0};
    assign twice_abs = twice[DW-1] ? (~twice + DW'(1)) : twice;
    assign rnd_sum   = prod_reg + ROUND_HALF;

    // diff << FRAC_BITS plus half the divisor (twice >>> 1, sign-extended)
    assign num_calc  = ({{(PW-DW){diff_reg[DW-1]}}, diff_reg} << FRAC_BITS)
                     + {{(PW-DW+1){guess_reg[DW-2]}}, guess_reg[DW-2:0]};
    assign num_abs   = num_reg[PW-1] ? (~num_reg + PW'(1)) : num_reg;

    // restoring divider step
    assign div_shift = {rem_reg, dq_reg[PW-1]};
    assign div_trial = {1'b0, div_shift} - {2'b00, den_reg};
    assign div_ge    = !div_trial[DW+1];
    assign quot      = neg_reg ? (~dq_reg[DW-1:0] + DW'(1)) : dq_reg[DW-1:0];

    assign out_free  = !out_valid_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        iter_count_next = iter_count_reg;
        step_next       = step_reg;
        cnt_next        = cnt_reg;
        rad_next        = rad_reg;
        guess_next      = guess_reg;
        dz_next         = dz_reg;
        prod_next       = prod_reg;
        diff_next       = diff_reg;
        num_next        = num_reg;
        dq_next         = dq_reg;
        rem_next        = rem_reg;
        den_next        = den_reg;
        neg_next        = neg_reg;
        out_valid_next  = out_valid_reg;
        out_root_next   = out_root_reg;
        out_dz_next     = out_dz_reg;

        if (cfg_valid) begin
            iter_count_next = cfg_data;
        end
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    rad_next   = s_radicand;
                    guess_next = INIT_GUESS;
                    dz_next    = 1'b0;
                    step_next  = '0;
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                state_next = (step_reg == iter_count_reg) ? ST_FIN : ST_MUL;
            end
            ST_MUL: begin
                prod_next  = PW'($signed(guess_reg) * $signed(guess_reg));
                state_next = ST_RND;
            end
            ST_RND: begin
                diff_next  = rnd_sum[FRAC_BITS +: DW] - rad_reg;
                state_next = ST_NUM;
            end
            ST_NUM: begin
                if (guess_reg[DW-2:0] == '0) begin
                    // doubled guess wrapped to zero: quotient taken as 0
                    dz_next    = 1'b1;
                    step_next  = step_reg + IW'(1);
                    state_next = ST_CHK;
                end else begin
                    num_next   = num_calc;
                    state_next = ST_ABS;
                end
            end
            ST_ABS: begin
                dq_next    = num_abs;
                den_next   = twice_abs;
                neg_next   = num_reg[PW-1] ^ twice[DW-1];
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                dq_next  = {dq_reg[PW-2:0], div_ge};
                rem_next = div_ge ? div_trial[DW-1:0] : div_shift[DW-1:0];
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                // all quotient bits are in, apply the step
                guess_next = guess_reg - quot;
                step_next  = step_reg + IW'(1);
                state_next = ST_CHK;
            end
            ST_FIN: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_root_next  = guess_reg;
                    out_dz_next    = dz_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            iter_count_reg <= fpns_pkg::ITER_COUNT_RESET;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            iter_count_reg <= iter_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg     <= step_next;
        cnt_reg      <= cnt_next;
        rad_reg      <= rad_next;
        guess_reg    <= guess_next;
        dz_reg       <= dz_next;
        prod_reg     <= prod_next;
        diff_reg     <= diff_next;
        num_reg      <= num_next;
        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        neg_reg      <= neg_next;
        out_root_reg <= out_root_next;
        out_dz_reg   <= out_dz_next;
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign cfg_ready        = 1'b1;
    assign m_valid          = out_valid_reg;
    assign m_root           = out_root_reg;
    assign m_divide_by_zero = out_dz_reg;

    // divider remainder always stays below the divisor
    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    // divider counts one quotient bit per cycle without leaving early
    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && cnt_reg != DIV_LAST) |=>
        (state_reg == ST_DIV && cnt_reg == $past(cnt_reg) + CW'(1)))
        else $error("divider sequence broken");

    // a result appears only out of the final state
    a_out_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result loaded outside final state");

    // the guess update follows the last divider cycle, after which the loop is tested
    a_upd_then_chk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD) |=> (state_reg == ST_CHK))
        else $error("guess update not followed by loop test");

endmodule
// ----------------------------------------------------------------------------

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks fixed_point_newton_sqrt: a table of directed radicands, then random
// phases at varied Newton step counts. Both handshakes stall at random. Each
// result is compared with its table value or an in-bench Newton predictor.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DATA_W = fpns_pkg::DATA_W;
    localparam int ITER_W = fpns_pkg::ITER_W;
    localparam int FRAC   = fpns_pkg::FRAC_BITS_DEFAULT;

    localparam logic signed [DATA_W-1:0] TEN      = fpns_pkg::GUESS_INT << FRAC;
    localparam logic signed [DATA_W-1:0] ONE      = 32'sd1 << FRAC;
    localparam logic signed [DATA_W-1:0] HUNDRED  = 32'sd100 << FRAC;
    localparam logic signed [DATA_W-1:0] NEG_HUND = -(32'sd100 << FRAC);
    localparam logic signed [DATA_W-1:0] MAX_RAD  = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] MIN_RAD  = 32'sh8000_0000;

    localparam int DIR_ROWS      = 23;
    localparam int RANDOM_ITEMS  = 930;
    localparam int DRAIN_LIMIT   = 40000;
    localparam int SETTLE_CYCLES = 200;

    typedef struct packed {
        logic signed [DATA_W-1:0] root;
        logic                     dz;
    } sqrt_result_t;

    typedef struct packed {
        logic [ITER_W-1:0]        steps;
        logic signed [DATA_W-1:0] radicand;
        logic                     typed;
        logic signed [DATA_W-1:0] root;
        logic                     dz;
    } directed_row_t;

    logic                     aclk;
    logic                     aresetn          = 1'b0;
    logic                     s_valid          = 1'b0;
    logic                     s_ready;
    logic signed [DATA_W-1:0] s_radicand       = '0;
    logic                     m_valid;
    logic                     m_ready          = 1'b0;
    logic signed [DATA_W-1:0] m_root;
    logic                     m_divide_by_zero;
    logic                     cfg_valid        = 1'b0;
    logic                     cfg_ready;
    logic [ITER_W-1:0]        cfg_data         = '0;

    sqrt_result_t      pending_roots[$];
    logic [ITER_W-1:0] step_count     = fpns_pkg::ITER_COUNT_RESET;
    int                mismatch_count = 0;
    bit                burst          = 1'b0;

    fixed_point_newton_sqrt #(
        .FRAC_BITS(FRAC)
    ) i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_radicand       (s_radicand),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_root           (m_root),
        .m_divide_by_zero (m_divide_by_zero),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #100ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // newton steps from the guess 10.0, every 32-bit result wrapping
    function automatic sqrt_result_t newton_root(logic signed [DATA_W-1:0] rad,
                                                 logic [ITER_W-1:0] steps);
        logic signed [DATA_W-1:0] guess;
        logic signed [DATA_W-1:0] twice;
        logic signed [DATA_W-1:0] diff;
        logic signed [DATA_W-1:0] quot;
        longint                   prod;
        longint                   num;
        sqrt_result_t             res;
        guess  = TEN;
        res.dz = 1'b0;
        for (int k = 0; k < steps; k++) begin
            twice = guess << 1;
            prod  = longint'(guess) * longint'(guess) + (longint'(1) << (FRAC - 1));
            diff  = DATA_W'(prod >>> FRAC) - rad;
            if (twice == 0) begin
                res.dz = 1'b1;
                quot   = '0;
            end else begin
                num  = (longint'(diff) <<< FRAC) + longint'(twice >>> 1);
                quot = DATA_W'(num / longint'(twice));
            end
            guess = guess - quot;
        end
        res.root = guess;
        return res;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_radicand();
        logic signed [DATA_W-1:0] r;
        case ($urandom_range(9))
            0, 1, 2, 3: r = $urandom;
            4, 5, 6:    r = $urandom_range(0, 32'h00ff_ffff);
            7:          r = 32'sd0 - $urandom_range(1, 32'h00ff_ffff);
            8:          r = $urandom_range(32'h0100_0000, 32'h7fff_ffff);
            default: begin
                case ($urandom_range(7))
                    0:       r = '0;
                    1:       r = 32'sd1;
                    2:       r = -32'sd1;
                    3:       r = MAX_RAD;
                    4:       r = MIN_RAD;
                    5:       r = HUNDRED;
                    6:       r = NEG_HUND;
                    default: r = ONE;
                endcase
            end
        endcase
        return r;
    endfunction

    // one radicand transfer; valid is only lowered for an idle gap
    task automatic send_radicand(input logic signed [DATA_W-1:0] rad, input bit typed,
                                 input sqrt_result_t typed_res);
        while (!burst && $urandom_range(99) < 33) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_radicand <= rad;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (typed) begin
            pending_roots.push_back(typed_res);
        end else begin
            pending_roots.push_back(newton_root(rad, step_count));
        end
    endtask

    // only written once every outstanding result has been taken
    task automatic write_step_count(input logic [ITER_W-1:0] steps);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_roots.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= steps;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid  <= 1'b0;
        step_count  = steps;
    endtask

    always @(posedge aclk) begin : check_results
        sqrt_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_roots.size() == 0) begin
                $display("%0t: unexpected result root %h dz %b", $time, m_root,
                         m_divide_by_zero);
                mismatch_count++;
            end else begin
                want = pending_roots.pop_front();
                if (m_root !== want.root) begin
                    $display("%0t: root mismatch, expected %h, actual %h", $time,
                             want.root, m_root);
                    mismatch_count++;
                end
                if (m_divide_by_zero !== want.dz) begin
                    $display("%0t: divide_by_zero mismatch, expected %b, actual %b",
                             $time, want.dz, m_divide_by_zero);
                    mismatch_count++;
                end
            end
        end
        m_ready <= burst || ($urandom_range(99) >= 33);
    end

    initial begin : stimulus
        directed_row_t     dir_rows [DIR_ROWS];
        sqrt_result_t      typed_res;
        logic [ITER_W-1:0] steps;
        int                sent;
        int                phase;
        int                phase_len;
        int                waited;

        // -100.0 drives the guess to exactly zero after one step, so every
        // later step meets a zero divisor
        dir_rows = '{
            '{8'd8,   HUNDRED,  1'b1, TEN,  1'b0},
            '{8'd8,   NEG_HUND, 1'b1, 32'sd0, 1'b1},
            '{8'd8,   32'sd0,   1'b0, 32'sd0, 1'b0},
            '{8'd8,   32'sd1,   1'b0, 32'sd0, 1'b0},
            '{8'd8,   -32'sd1,  1'b0, 32'sd0, 1'b0},
            '{8'd8,   MAX_RAD,  1'b0, 32'sd0, 1'b0},
            '{8'd8,   MIN_RAD,  1'b0, 32'sd0, 1'b0},
            '{8'd8,   ONE,      1'b0, 32'sd0, 1'b0},
            '{8'd8,   ONE << 2, 1'b0, 32'sd0, 1'b0},
            '{8'd0,   MAX_RAD,  1'b1, TEN,  1'b0},
            '{8'd0,   MIN_RAD,  1'b1, TEN,  1'b0},
            '{8'd0,   NEG_HUND, 1'b1, TEN,  1'b0},
            '{8'd1,   NEG_HUND, 1'b1, 32'sd0, 1'b0},
            '{8'd1,   HUNDRED,  1'b1, TEN,  1'b0},
            '{8'd1,   MAX_RAD,  1'b0, 32'sd0, 1'b0},
            '{8'd2,   NEG_HUND, 1'b1, 32'sd0, 1'b1},
            '{8'd2,   ONE << 1, 1'b0, 32'sd0, 1'b0},
            '{8'd255, HUNDRED,  1'b1, TEN,  1'b0},
            '{8'd255, NEG_HUND, 1'b1, 32'sd0, 1'b1},
            '{8'd255, MAX_RAD,  1'b0, 32'sd0, 1'b0},
            '{8'd255, MIN_RAD,  1'b0, 32'sd0, 1'b0},
            '{8'd8,   ONE << 1, 1'b0, 32'sd0, 1'b0},
            '{8'd8,   32'sh7fff_0000, 1'b0, 32'sd0, 1'b0}
        };

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_rows[i].steps != step_count) write_step_count(dir_rows[i].steps);
            typed_res.root = dir_rows[i].root;
            typed_res.dz   = dir_rows[i].dz;
            send_radicand(dir_rows[i].radicand, dir_rows[i].typed, typed_res);
        end

        // random phases, mostly short step counts to keep the run bounded
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(9) == 0) steps = $urandom_range(13, 24);
            else steps = $urandom_range(0, 10);
            write_step_count(steps);
            burst     = (phase == 1) || (phase == 5);
            phase_len = burst ? 60 : $urandom_range(20, 60);
            for (int j = 0; j < phase_len && sent < RANDOM_ITEMS; j++) begin
                send_radicand(pick_radicand(), 1'b0, '0);
                sent++;
            end
            burst = 1'b0;
            phase++;
        end
        s_valid <= 1'b0;

        waited = 0;
        while (pending_roots.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_roots.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_roots.size());
            mismatch_count += pending_roots.size();
        end

        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
// ----------------------------------------------------------------------------
